// ----- sv/srb_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// srb_pkg
// Shared types and constants for the seed registration backoff block.
// ----------------------------------------------------------------------------
package srb_pkg;

   localparam int NUM_SEEDS = 8;
   localparam int SEED_W    = $clog2(NUM_SEEDS);
   localparam int CNT_W     = SEED_W + 1;

   localparam logic [CNT_W-1:0] NUM_SEEDS_CNT = CNT_W'(NUM_SEEDS);

   localparam logic OP_TICK = 1'b0;
   localparam logic OP_ACK  = 1'b1;

   localparam logic ACT_REGISTER  = 1'b0;
   localparam logic ACT_FIND_NODE = 1'b1;

   localparam logic [2:0] REG_SEED_COUNT    = 3'd0;
   localparam logic [2:0] REG_INITIAL_DELAY = 3'd1;
   localparam logic [2:0] REG_DELAY_CAP     = 3'd2;
   localparam logic [2:0] REG_RETRY_LIMIT   = 3'd3;
   localparam logic [2:0] REG_RECOVERY_WAIT = 3'd4;

   typedef enum logic [2:0] {
      LS_DISCONNECTED = 3'd0,
      LS_CONNECTING   = 3'd1,
      LS_CONNECTED    = 3'd2,
      LS_FAILED       = 3'd3,
      LS_VERIFIED     = 3'd4
   } link_state_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_MODIFY,
      S_DISCOVER,
      S_FIND,
      S_FLUSH
   } ctrl_state_type;

   typedef struct packed {
      link_state_type st;
      logic [3:0]     cnt;
      logic [5:0]     delay;
      logic [31:0]    last_time;
   } rec_type;

   localparam rec_type REC_RESET = '{
      st:        LS_DISCONNECTED,
      cnt:       4'd0,
      delay:     6'd2,
      last_time: 32'd0
   };

   typedef struct packed {
      logic [3:0]  seed_count;
      logic [5:0]  initial_delay;
      logic [5:0]  delay_cap;
      logic [3:0]  retry_limit;
      logic [15:0] recovery_wait;
   } cfg_type;

   typedef struct packed {
      logic        opcode;
      logic [2:0]  seed_index;
      logic        ack_rejected;
      logic [31:0] current_time;
      logic        identity_valid;
      logic [7:0]  key_known_mask;
   } item_type;

   typedef struct packed {
      logic              we;
      logic [SEED_W-1:0] waddr;
      rec_type           wdata;
      logic [SEED_W-1:0] raddr;
   } mem_cmd_type;

   typedef struct packed {
      rec_type rec;
      logic    emit;
      logic    not_verified;
   } upd_type;

endpackage
`default_nettype wire

// ----- sv/srb_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// srb_req_if / srb_rsp_if
// Valid/ready channels for requests into and results out of the block.
// ----------------------------------------------------------------------------
interface srb_req_if;
   logic        valid;
   logic        ready;
   logic        opcode;
   logic [2:0]  seed_index;
   logic        ack_rejected;
   logic [31:0] current_time;
   logic        identity_valid;
   logic [7:0]  key_known_mask;

   modport source (output valid, opcode, seed_index, ack_rejected, current_time,
                   identity_valid, key_known_mask, input ready);
   modport sink (input valid, opcode, seed_index, ack_rejected, current_time,
                 identity_valid, key_known_mask, output ready);
endinterface

interface srb_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] target_seed;
   logic       action;
   logic       last;

   modport source (output valid, target_seed, action, last, input ready);
   modport sink (input valid, target_seed, action, last, output ready);
endinterface
`default_nettype wire

// ----- sv/srb_rec_mem.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// srb_rec_mem
// Per-seed record memory, one write and one registered read per cycle.
// Entries not yet written read back as the reset record.
// ----------------------------------------------------------------------------
module srb_rec_mem (
   input  wire                  clock,
   input  wire                  reset,
   input  srb_pkg::mem_cmd_type cmd,
   output srb_pkg::rec_type     rd_rec
);

   srb_pkg::rec_type                recs_ff [srb_pkg::NUM_SEEDS];
   logic [srb_pkg::NUM_SEEDS-1:0]   valid_ff;
   srb_pkg::rec_type                rd_data_ff;
   logic                            rd_valid_ff;

   always_ff @(posedge clock) begin
      if (cmd.we) begin
         recs_ff[cmd.waddr] <= cmd.wdata;
      end
      rd_data_ff <= recs_ff[cmd.raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (cmd.we) begin
            valid_ff[cmd.waddr] <= 1'b1;
         end
         rd_valid_ff <= valid_ff[cmd.raddr];
      end
   end

   assign rd_rec = rd_valid_ff ? rd_data_ff : srb_pkg::REC_RESET;

endmodule
`default_nettype wire

// ----- sv/srb_update.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// srb_update
// Next-record logic for one seed: backoff, retry limit, recovery, key check, ack.
// ----------------------------------------------------------------------------
module srb_update (
   input  srb_pkg::item_type            item,
   input  wire [srb_pkg::SEED_W-1:0]    idx,
   input  srb_pkg::cfg_type             cfg,
   input  srb_pkg::rec_type             rec,
   output srb_pkg::upd_type             upd
);

   logic [31:0] retry_due;
   logic [31:0] recover_due;
   logic [6:0]  dbl_delay;
   logic [4:0]  cnt_inc;
   logic [4:0]  cnt_sent;

   assign retry_due   = rec.last_time + {26'd0, rec.delay};
   assign recover_due = rec.last_time + {16'd0, cfg.recovery_wait};
   assign dbl_delay   = {rec.delay, 1'b0};
   assign cnt_inc     = {1'b0, rec.cnt} + 5'd1;
   assign cnt_sent    = cnt_inc + 5'd1;

   always_comb begin
      upd.rec          = rec;
      upd.emit         = 1'b0;
      upd.not_verified = 1'b0;
      if (item.opcode == srb_pkg::OP_ACK) begin
         upd.rec.st = item.ack_rejected ? srb_pkg::LS_FAILED : srb_pkg::LS_CONNECTED;
      end else if (rec.st == srb_pkg::LS_VERIFIED) begin
         // verified seeds are left alone
      end else if (!item.identity_valid) begin
         upd.not_verified = 1'b1;
      end else begin
         unique case (rec.st)
            srb_pkg::LS_DISCONNECTED: begin
               upd.emit          = 1'b1;
               upd.rec.st        = srb_pkg::LS_CONNECTING;
               upd.rec.cnt       = 4'd1;
               upd.rec.delay     = cfg.initial_delay;
               upd.rec.last_time = item.current_time;
               upd.not_verified  = 1'b1;
            end
            srb_pkg::LS_CONNECTING: begin
               upd.not_verified = 1'b1;
               if (item.current_time > retry_due) begin
                  upd.rec.delay = (dbl_delay < {1'b0, cfg.delay_cap}) ?
                                  dbl_delay[5:0] : cfg.delay_cap;
                  if (cnt_inc <= {1'b0, cfg.retry_limit}) begin
                     upd.emit          = 1'b1;
                     upd.rec.last_time = item.current_time;
                     upd.rec.cnt       = (cnt_sent > 5'd15) ? 4'd15 : cnt_sent[3:0];
                  end else begin
                     upd.rec.st  = srb_pkg::LS_FAILED;
                     upd.rec.cnt = (cnt_inc > 5'd15) ? 4'd15 : cnt_inc[3:0];
                  end
               end
            end
            srb_pkg::LS_CONNECTED: begin
               if (item.key_known_mask[idx]) begin
                  upd.rec.st = srb_pkg::LS_VERIFIED;
               end else begin
                  upd.not_verified = 1'b1;
               end
            end
            srb_pkg::LS_FAILED: begin
               upd.not_verified = 1'b1;
               if (item.current_time > recover_due) begin
                  upd.rec.st    = srb_pkg::LS_DISCONNECTED;
                  upd.rec.cnt   = 4'd0;
                  upd.rec.delay = cfg.initial_delay;
               end
            end
            default: begin
               upd.not_verified = 1'b1;
            end
         endcase
      end
   end

endmodule
`default_nettype wire

// ----- sv/srb_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// srb_ctrl
// Sequencer: walks the seeds through read/modify/write, holds one pending
// result so the final one of a tick can be flagged, and drives the output
// register.
// ----------------------------------------------------------------------------
module srb_ctrl (
   input  wire                          clock,
   input  wire                          reset,
   input  srb_pkg::cfg_type             cfg,
   srb_req_if.sink                      req_ch,
   srb_rsp_if.source                    rsp_ch,
   input  srb_pkg::upd_type             upd,
   output srb_pkg::item_type            item,
   output logic [srb_pkg::SEED_W-1:0]   idx,
   output srb_pkg::mem_cmd_type         mem_cmd
);

   srb_pkg::ctrl_state_type           state_ff, state_in;
   srb_pkg::item_type                 item_ff, item_in;
   logic [srb_pkg::SEED_W-1:0]        idx_ff, idx_in;
   logic                              all_ver_ff, all_ver_in;
   logic                              disc_done_ff, disc_done_in;
   logic                              pend_valid_ff, pend_valid_in;
   logic [srb_pkg::SEED_W-1:0]        pend_seed_ff, pend_seed_in;
   logic                              pend_action_ff, pend_action_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [2:0]                        rsp_seed_ff, rsp_seed_in;
   logic                              rsp_action_ff, rsp_action_in;
   logic                              rsp_last_ff, rsp_last_in;

   logic [srb_pkg::CNT_W-1:0]         seeds_used;
   logic                              accept;
   logic                              can_push;
   logic                              last_seed;
   logic                              ack_in_range;
   logic                              mod_stall;
   logic                              find_stall;
   logic                              push_en;
   logic                              push_last;

   assign seeds_used = (cfg.seed_count > srb_pkg::NUM_SEEDS_CNT) ?
                       srb_pkg::NUM_SEEDS_CNT : cfg.seed_count;
   assign accept       = req_ch.valid && req_ch.ready;
   assign can_push     = !rsp_valid_ff || rsp_ch.ready;
   assign last_seed    = ({1'b0, idx_ff} + 1'b1) == seeds_used;
   assign ack_in_range = {1'b0, req_ch.seed_index} < seeds_used;
   assign mod_stall    = upd.emit && pend_valid_ff && !can_push;
   assign find_stall   = pend_valid_ff && !can_push;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         srb_pkg::S_IDLE: begin
            if (accept) begin
               if (req_ch.opcode == srb_pkg::OP_ACK) begin
                  state_in = ack_in_range ? srb_pkg::S_READ : srb_pkg::S_IDLE;
               end else begin
                  state_in = (seeds_used != '0) ? srb_pkg::S_READ : srb_pkg::S_IDLE;
               end
            end
         end
         srb_pkg::S_READ: begin
            state_in = srb_pkg::S_MODIFY;
         end
         srb_pkg::S_MODIFY: begin
            priority if (mod_stall) begin
               state_in = srb_pkg::S_MODIFY;
            end else if (item_ff.opcode == srb_pkg::OP_ACK) begin
               state_in = srb_pkg::S_IDLE;
            end else if (last_seed) begin
               state_in = srb_pkg::S_DISCOVER;
            end else begin
               state_in = srb_pkg::S_READ;
            end
         end
         srb_pkg::S_DISCOVER: begin
            state_in = (!disc_done_ff && all_ver_ff) ? srb_pkg::S_FIND : srb_pkg::S_FLUSH;
         end
         srb_pkg::S_FIND: begin
            if (!find_stall && last_seed) begin
               state_in = srb_pkg::S_FLUSH;
            end
         end
         srb_pkg::S_FLUSH: begin
            if (!pend_valid_ff || can_push) begin
               state_in = srb_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = srb_pkg::S_IDLE;
         end
      endcase
   end

   // datapath and outputs
   always_comb begin
      item_in        = item_ff;
      idx_in         = idx_ff;
      all_ver_in     = all_ver_ff;
      disc_done_in   = disc_done_ff;
      pend_valid_in  = pend_valid_ff;
      pend_seed_in   = pend_seed_ff;
      pend_action_in = pend_action_ff;
      push_en        = 1'b0;
      push_last      = 1'b0;
      mem_cmd.we     = 1'b0;
      mem_cmd.waddr  = idx_ff;
      mem_cmd.wdata  = upd.rec;
      mem_cmd.raddr  = idx_ff;
      unique case (state_ff)
         srb_pkg::S_IDLE: begin
            if (accept) begin
               item_in.opcode         = req_ch.opcode;
               item_in.seed_index     = req_ch.seed_index;
               item_in.ack_rejected   = req_ch.ack_rejected;
               item_in.current_time   = req_ch.current_time;
               item_in.identity_valid = req_ch.identity_valid;
               item_in.key_known_mask = req_ch.key_known_mask;
               idx_in     = (req_ch.opcode == srb_pkg::OP_ACK) ?
                            req_ch.seed_index[srb_pkg::SEED_W-1:0] : '0;
               all_ver_in = 1'b1;
            end
         end
         srb_pkg::S_READ: begin
         end
         srb_pkg::S_MODIFY: begin
            if (!mod_stall) begin
               mem_cmd.we = 1'b1;
               if (upd.emit) begin
                  push_en        = pend_valid_ff;
                  pend_valid_in  = 1'b1;
                  pend_seed_in   = idx_ff;
                  pend_action_in = srb_pkg::ACT_REGISTER;
               end
               if (upd.not_verified) begin
                  all_ver_in = 1'b0;
               end
               if (!last_seed) begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         srb_pkg::S_DISCOVER: begin
            if (!disc_done_ff && all_ver_ff) begin
               disc_done_in = 1'b1;
               idx_in       = '0;
            end
         end
         srb_pkg::S_FIND: begin
            if (!find_stall) begin
               push_en        = pend_valid_ff;
               pend_valid_in  = 1'b1;
               pend_seed_in   = idx_ff;
               pend_action_in = srb_pkg::ACT_FIND_NODE;
               if (!last_seed) begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         srb_pkg::S_FLUSH: begin
            if (pend_valid_ff && can_push) begin
               push_en       = 1'b1;
               push_last     = 1'b1;
               pend_valid_in = 1'b0;
            end
         end
         default: begin
         end
      endcase

      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_seed_in   = rsp_seed_ff;
      rsp_action_in = rsp_action_ff;
      rsp_last_in   = rsp_last_ff;
      if (push_en) begin
         rsp_valid_in  = 1'b1;
         rsp_seed_in   = 3'(pend_seed_ff);
         rsp_action_in = pend_action_ff;
         rsp_last_in   = push_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= srb_pkg::S_IDLE;
         disc_done_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         disc_done_ff  <= disc_done_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff        <= item_in;
      idx_ff         <= idx_in;
      all_ver_ff     <= all_ver_in;
      pend_seed_ff   <= pend_seed_in;
      pend_action_ff <= pend_action_in;
      rsp_seed_ff    <= rsp_seed_in;
      rsp_action_ff  <= rsp_action_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign req_ch.ready       = (state_ff == srb_pkg::S_IDLE);
   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.target_seed = rsp_seed_ff;
   assign rsp_ch.action      = rsp_action_ff;
   assign rsp_ch.last        = rsp_last_ff;
   assign item               = item_ff;
   assign idx                = idx_ff;

endmodule
`default_nettype wire

// ----- sv/seed_registration_backoff.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// seed_registration_backoff
// Registration and retry backoff bookkeeping for up to NUM_SEEDS seeds.
// ----------------------------------------------------------------------------
// Tick: each seed in use gets a record read, then a modify/write back; then
//   discovery is decided, any find-node requests are issued, and the final
//   result is flagged. Ack: record read, then modify/write back.
// Each result waits in a holding register until the next is known.
// Reset: per-seed valid bits clear at once, so records read as reset values
//   with no clearing pass; config registers return to their reset values.
// ----------------------------------------------------------------------------
module seed_registration_backoff (
   input  wire        clock,
   input  wire        reset,
   srb_req_if.sink    req_ch,
   srb_rsp_if.source  rsp_ch,
   input  wire        csr_we,
   input  wire [2:0]  csr_index,
   input  wire [15:0] csr_wdata
);

   srb_pkg::cfg_type              cfg_ff, cfg_in;
   srb_pkg::item_type             item;
   logic [srb_pkg::SEED_W-1:0]    idx;
   srb_pkg::mem_cmd_type          mem_cmd;
   srb_pkg::rec_type              rd_rec;
   srb_pkg::upd_type              upd;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            srb_pkg::REG_SEED_COUNT:    cfg_in.seed_count    = csr_wdata[3:0];
            srb_pkg::REG_INITIAL_DELAY: cfg_in.initial_delay = csr_wdata[5:0];
            srb_pkg::REG_DELAY_CAP:     cfg_in.delay_cap     = csr_wdata[5:0];
            srb_pkg::REG_RETRY_LIMIT:   cfg_in.retry_limit   = csr_wdata[3:0];
            srb_pkg::REG_RECOVERY_WAIT: cfg_in.recovery_wait = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.seed_count    <= 4'd0;
         cfg_ff.initial_delay <= 6'd2;
         cfg_ff.delay_cap     <= 6'd60;
         cfg_ff.retry_limit   <= 4'd10;
         cfg_ff.recovery_wait <= 16'd300;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   srb_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .req_ch  (req_ch),
      .rsp_ch  (rsp_ch),
      .upd     (upd),
      .item    (item),
      .idx     (idx),
      .mem_cmd (mem_cmd)
   );

   srb_rec_mem u_rec_mem (
      .clock  (clock),
      .reset  (reset),
      .cmd    (mem_cmd),
      .rd_rec (rd_rec)
   );

   srb_update u_update (
      .item (item),
      .idx  (idx),
      .cfg  (cfg_ff),
      .rec  (rd_rec),
      .upd  (upd)
   );

endmodule
`default_nettype wire
